[src/wsfe_pkg.sv]
// Shared constants and types for the WebSocket frame encoder.
`timescale 1ns / 1ps
package wsfe_pkg;

  localparam int unsigned HDR_MAX_BYTES = 14;
  localparam int unsigned HDR_BITS      = HDR_MAX_BYTES * 8;
  localparam int unsigned HDR_CNT_W     = $clog2(HDR_MAX_BYTES + 1);

  localparam logic [7:0]  FIN_BIT     = 8'h80;
  localparam logic [7:0]  MASK_BIT    = 8'h80;
  localparam logic [3:0]  OPCODE_MASK = 4'hF;
  localparam logic [6:0]  LEN_CODE_16 = 7'd126;
  localparam logic [6:0]  LEN_CODE_64 = 7'd127;
  localparam logic [63:0] LEN_MAX_16  = 64'h0000_0000_0000_FFFF;

  // Byte counts of the header variants, without and with the key.
  localparam logic [HDR_CNT_W-1:0] HDR_CNT_7   = HDR_CNT_W'(2);
  localparam logic [HDR_CNT_W-1:0] HDR_CNT_16  = HDR_CNT_W'(4);
  localparam logic [HDR_CNT_W-1:0] HDR_CNT_64  = HDR_CNT_W'(10);
  localparam logic [HDR_CNT_W-1:0] HDR_CNT_KEY = HDR_CNT_W'(4);

  // Built header: byte 0 goes out first, taken from bits [7:0].
  typedef struct packed {
    logic [HDR_BITS-1:0]  bytes;
    logic [HDR_CNT_W-1:0] count;
    logic                 empty_frame;
  } hdr_t;

endpackage

[src/wsfe_hdr_build.sv]
// Header byte builder: fin/opcode, length code, extended length and key.
`timescale 1ns / 1ps
module wsfe_hdr_build
  import wsfe_pkg::*;
(
  input  logic        final_fragment,
  input  logic [3:0]  frame_opcode,
  input  logic        mask_enable,
  input  logic [31:0] mask_key,
  input  logic [63:0] payload_length,
  output hdr_t        hdr
);

  logic [7:0]  b0;
  logic [7:0]  mbit;
  logic [63:0] len_be;
  logic        short_len;
  logic        mid_len;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      len_be[8*i +: 8] = payload_length[8*(7-i) +: 8];
    end
  end

  assign b0        = (final_fragment ? FIN_BIT : 8'h00) | {4'h0, frame_opcode & OPCODE_MASK};
  assign mbit      = mask_enable ? MASK_BIT : 8'h00;
  assign short_len = payload_length < 64'(LEN_CODE_16);
  assign mid_len   = payload_length <= LEN_MAX_16;

  always_comb begin
    hdr.bytes = '0;
    hdr.bytes[7:0] = b0;
    if (short_len) begin
      hdr.bytes[15:8] = mbit | {1'b0, payload_length[6:0]};
      if (mask_enable) hdr.bytes[47:16] = mask_key;
      hdr.count = HDR_CNT_7;
    end else if (mid_len) begin
      hdr.bytes[15:8]  = mbit | {1'b0, LEN_CODE_16};
      hdr.bytes[23:16] = payload_length[15:8];
      hdr.bytes[31:24] = payload_length[7:0];
      if (mask_enable) hdr.bytes[63:32] = mask_key;
      hdr.count = HDR_CNT_16;
    end else begin
      hdr.bytes[15:8]  = mbit | {1'b0, LEN_CODE_64};
      hdr.bytes[79:16] = len_be;
      if (mask_enable) hdr.bytes[111:80] = mask_key;
      hdr.count = HDR_CNT_64;
    end
    if (mask_enable) hdr.count = hdr.count + HDR_CNT_KEY;
    hdr.empty_frame = (payload_length == 64'd0);
  end

endmodule

[src/websocket_frame_encoder_core.sv]
// Top level of the WebSocket frame encoder: byte-stream framing per RFC 6455.
`timescale 1ns / 1ps
// Turns header and payload words into the byte stream of WebSocket frames.
// A header word (mode 0) is taken, opens a new frame (abandoning any
// unfinished one) and then plays out its 2 to 14 header bytes, one per
// cycle while the output register is free, from a header shift register;
// the input stays stalled until that burst has drained. A payload word
// (mode 1) is masked with the held key byte selected by the key phase and
// is registered in the output register, so payload streams at one byte per
// cycle as long as the output word is taken downstream every cycle; an
// output word left waiting stalls the input. A payload word with no frame
// open yields one word with stray_error set and out_byte 0. frame_last
// marks a frame's final byte, run_last the last byte caused by an input
// word. There is no configuration; reset clears all frame state.
module websocket_frame_encoder_core
  import wsfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic        final_fragment,
  input  logic [3:0]  frame_opcode,
  input  logic        mask_enable,
  input  logic [31:0] mask_key,
  input  logic [63:0] payload_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_last,
  output logic        run_last,
  output logic        stray_error
);

  // Frame state
  logic        frame_open;
  logic [63:0] bytes_remaining;
  logic [31:0] held_key;
  logic        masking_active;
  logic [1:0]  key_phase;

  // Header burst: shift register, bytes left, empty-frame flag
  logic [HDR_BITS-1:0]  hdr_buf;
  logic [HDR_CNT_W-1:0] hdr_left;
  logic                 hdr_empty;

  hdr_t hdr;

  logic out_free;
  logic in_fire;
  logic hdr_take;
  logic hdr_final;
  logic [7:0] key_byte;
  logic [7:0] masked_byte;

  wsfe_hdr_build u_hdr_build (
    .final_fragment (final_fragment),
    .frame_opcode   (frame_opcode),
    .mask_enable    (mask_enable),
    .mask_key       (mask_key),
    .payload_length (payload_length),
    .hdr            (hdr)
  );

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (hdr_left == '0) && out_free;
  assign in_fire   = in_valid && in_ready;
  // burst drains into the output register whenever it is free
  assign hdr_take  = (hdr_left != '0) && out_free;
  assign hdr_final = (hdr_left == HDR_CNT_W'(1));

  assign key_byte    = held_key[8*key_phase +: 8];
  assign masked_byte = masking_active ? (data_byte ^ key_byte) : data_byte;

  // Frame state and header burst
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= '0;
      held_key        <= '0;
      masking_active  <= 1'b0;
      key_phase       <= '0;
      hdr_left        <= '0;
    end else if (in_fire && !mode) begin
      frame_open      <= !hdr.empty_frame;
      bytes_remaining <= payload_length;
      held_key        <= mask_key;
      masking_active  <= mask_enable;
      key_phase       <= '0;
      hdr_left        <= hdr.count;
    end else if (in_fire && frame_open) begin
      key_phase       <= key_phase + 2'd1;
      bytes_remaining <= bytes_remaining - 64'd1;
      if (bytes_remaining == 64'd1) frame_open <= 1'b0;
    end else if (hdr_take) begin
      hdr_left <= hdr_left - HDR_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !mode) begin
      hdr_buf   <= hdr.bytes;
      hdr_empty <= hdr.empty_frame;
    end else if (hdr_take) begin
      hdr_buf   <= hdr_buf >> 8;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hdr_take || in_fire && mode) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_take) begin
      out_byte    <= hdr_buf[7:0];
      frame_last  <= hdr_final && hdr_empty;
      run_last    <= hdr_final;
      stray_error <= 1'b0;
    end else if (in_fire && mode) begin
      run_last <= 1'b1;
      if (frame_open) begin
        out_byte    <= masked_byte;
        frame_last  <= (bytes_remaining == 64'd1);
        stray_error <= 1'b0;
      end else begin
        // stray payload byte: dropped, flagged
        out_byte    <= 8'h00;
        frame_last  <= 1'b0;
        stray_error <= 1'b1;
      end
    end
  end

endmodule
